>>> rtl/hpq_pkg.sv
// hpq_pkg: types, sizes and codes shared by the binary min-heap queue.
// No dependencies; imported by hpq_ctrl and binary_min_heap_queue.
package hpq_pkg;

  localparam int CAPACITY = 128;
  localparam int KEY_W    = 32;
  localparam int ACT_W    = 2;
  localparam int SLOT_W   = 8;
  localparam int CNT_W    = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int POS_W    = $clog2(CAPACITY + 1);
  localparam int EXT_W    = (POS_W > SLOT_W) ? POS_W : SLOT_W;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_REPLACE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic signed [KEY_W-1:0] key;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } rsp_t;

  // finished request from the controller, registered at the top level
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } fin_t;

endpackage

>>> rtl/binary_min_heap_queue.sv
// binary_min_heap_queue: top level of the min-heap priority queue.
// Depends on hpq_pkg, hpq_ram and hpq_ctrl.
//
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+--------------------------------
// request   | in        | start_i high, busy_o low | req_i  (action, key, slot)
// result    | out       | done_o strobe, 1 cycle   | rsp_o  (min_key, status, count)
//
// Errors and the unused action finish in the accept cycle. Insert climbs from
// the new last slot to the root or stops below it; a replace that climbs does
// the same. Delete-min reads the root and the last key, then sinks level by
// level (into a lone left child on one read) until it stops; a replace that
// does not climb sinks the same way, after a parent compare off the root. The
// worst case is a replace of the root of a full heap that sinks to slot 128.
// The pace is set by the single-read-port key RAM: each level costs a parent
// read, or a left and a right child read, before the compare and write-back.
// The result strobe is registered, in the cycle after the controller finishes;
// by then busy_o is already low, so the next request may be taken alongside it.
// Reset clears state, key count and strobe; the key RAM needs no clearing
// since only slots 1..count are ever read. The receiver cannot stall results.
// Reads and writes never touch the same entry in one cycle, so no forwarding.
module binary_min_heap_queue import hpq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  fin_t              fin;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [KEY_W-1:0]  mem_rdata;

  logic done_q;
  rsp_t rsp_q;

  hpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .fin_o       (fin),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // key store, slot n lives at address n-1
  hpq_ram #(
    .DATA_W (KEY_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result register: one-cycle strobe, payload held until the next result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.valid) begin
      rsp_q <= fin.rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/hpq_ram.sv
// hpq_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
module hpq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/hpq_ctrl.sv
// hpq_ctrl: heap sequencer; runs insert, delete-min and replace as
// sift-up / sift-down walks over the key RAM. Depends on hpq_pkg.
module hpq_ctrl import hpq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  req_t              req_i,
  output logic              busy_o,
  output fin_t              fin_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [KEY_W-1:0]  mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [KEY_W-1:0]  mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_DN_CHK,
    S_DN_L,
    S_DN_R
  } state_e;

  state_e           state_q, state_d;
  logic [POS_W-1:0] count_q, count_d;
  logic [POS_W-1:0] pos_q, pos_d;
  key_t             key_q, key_d;
  key_t             min_q, min_d;
  key_t             lkey_q, lkey_d;
  logic             down_q, down_d;   // replace: sift down if no up move

  key_t             rdata;
  logic [POS_W:0]   lpos, rpos;
  logic             l_ok, r_ok;
  key_t             child_key;
  logic [POS_W:0]   child_pos;

  // one-based slot to RAM address
  function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] m;
    m = p - POS_W'(1);
    return m[ADDR_W-1:0];
  endfunction

  assign rdata = key_t'(mem_rdata_i);
  assign lpos  = {pos_q, 1'b0};
  assign rpos  = {pos_q, 1'b1};
  assign l_ok  = lpos <= {1'b0, count_q};
  assign r_ok  = rpos <= {1'b0, count_q};

  // left child wins ties
  always_comb begin
    if (rdata < lkey_q) begin
      child_key = rdata;
      child_pos = rpos;
    end else begin
      child_key = lkey_q;
      child_pos = lpos;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    key_d       = key_q;
    min_d       = min_q;
    lkey_d      = lkey_q;
    down_d      = down_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr_of(pos_q);
    mem_wdata_o = key_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_of(pos_q);
    fin_o.valid       = 1'b0;
    fin_o.rsp.min_key = min_q;
    fin_o.rsp.status  = ST_OK;
    fin_o.rsp.count   = CNT_W'(count_q);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          min_d  = '0;
          key_d  = req_i.key;
          down_d = 1'b0;
          fin_o.rsp.min_key = '0;
          case (req_i.action)
            ACT_INSERT: begin
              if (count_q == POS_W'(CAPACITY)) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = ST_FULL;
              end else begin
                count_d = count_q + POS_W'(1);
                pos_d   = count_q + POS_W'(1);
                state_d = S_UP_RD;
              end
            end
            ACT_DELETE: begin
              if (count_q == '0) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = ST_EMPTY;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                state_d     = S_DEL_ROOT;
              end
            end
            ACT_REPLACE: begin
              if (req_i.slot == '0 || EXT_W'(req_i.slot) > EXT_W'(count_q)) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = ST_BAD_SLOT;
              end else begin
                pos_d   = POS_W'(req_i.slot);
                down_d  = 1'b1;
                state_d = S_UP_RD;
              end
            end
            default: begin
              fin_o.valid = 1'b1;
            end
          endcase
        end
      end

      S_UP_RD: begin
        if (pos_q == POS_W'(1)) begin
          if (down_q) begin
            state_d = S_DN_CHK;
          end else begin
            mem_we_o    = 1'b1;
            fin_o.valid = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_of(pos_q >> 1);
          state_d     = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (key_q < rdata) begin
          // parent drops into the hole; once moved, no sift-down is needed
          mem_we_o    = 1'b1;
          mem_wdata_o = rdata;
          pos_d       = pos_q >> 1;
          down_d      = 1'b0;
          state_d     = S_UP_RD;
        end else if (down_q) begin
          state_d = S_DN_CHK;
        end else begin
          mem_we_o    = 1'b1;
          fin_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_DEL_ROOT: begin
        min_d       = rdata;
        mem_re_o    = 1'b1;
        mem_raddr_o = addr_of(count_q);
        count_d     = count_q - POS_W'(1);
        state_d     = S_DEL_LAST;
      end

      S_DEL_LAST: begin
        key_d = rdata;
        pos_d = POS_W'(1);
        if (count_q == '0) begin
          fin_o.valid = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_DN_CHK;
        end
      end

      S_DN_CHK: begin
        if (!l_ok) begin
          mem_we_o    = 1'b1;
          fin_o.valid = 1'b1;
          state_d     = S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_of(lpos[POS_W-1:0]);
          state_d     = S_DN_L;
        end
      end

      S_DN_L: begin
        if (r_ok) begin
          lkey_d      = rdata;
          mem_re_o    = 1'b1;
          mem_raddr_o = addr_of(rpos[POS_W-1:0]);
          state_d     = S_DN_R;
        end else if (rdata < key_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = rdata;
          pos_d       = lpos[POS_W-1:0];
          state_d     = S_DN_CHK;
        end else begin
          mem_we_o    = 1'b1;
          fin_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_DN_R: begin
        if (child_key < key_q) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = child_key;
          pos_d       = child_pos[POS_W-1:0];
          state_d     = S_DN_CHK;
        end else begin
          mem_we_o    = 1'b1;
          fin_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      down_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      down_q  <= down_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    key_q  <= key_d;
    min_q  <= min_d;
    lkey_q <= lkey_d;
  end

endmodule
